@@ hw/rtl/addressed_switch_command_controller_assert.svh @@
// Assertion macros for the files that check their own logic.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef ADDRESSED_SWITCH_COMMAND_CONTROLLER_ASSERT_SVH
`define ADDRESSED_SWITCH_COMMAND_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// A condition that holds on every clock edge out of reset.
`define ASC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its trigger.
`define ASC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that holds in the cycle after its trigger.
`define ASC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASC_ASSERT_ALWAYS(lbl, cond, msg)
`define ASC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ hw/rtl/asc_pkg.sv @@
package asc_pkg;

  // Receive buffer size as seen by the write index.
  localparam int BUFFER_SIZE  = 32;
  localparam int IDX_W        = $clog2(BUFFER_SIZE);
  // Only the leading frame positions are kept.
  localparam int KEPT_BYTES   = 10;
  localparam int ADDR_BYTES   = 8;
  localparam int CTRL_POS     = 8;
  localparam int DATA_POS     = 9;
  // Feedback frame.
  localparam int FEEDBACK_LEN = 11;
  localparam int CNT_W        = $clog2(FEEDBACK_LEN);
  // Command queue between front and back.
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  localparam int KIND_W       = 2;
  localparam int BYTE_W       = 8;
  localparam int ADDR_W       = 64;
  localparam int DEB_W        = 16;
  localparam int TIME_W       = 32;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDRESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS  = 8'd1;
  localparam logic [DEB_W-1:0]     DEBOUNCE_RESET   = 16'd200;

  // Link byte codes.
  localparam logic [BYTE_W-1:0] CTRL_SWITCH = 8'hC0;
  localparam logic [BYTE_W-1:0] DATA_ON     = 8'h0F;
  localparam logic [BYTE_W-1:0] DATA_OFF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CR_BYTE     = 8'h0D;
  localparam logic [BYTE_W-1:0] FB_TAG      = 8'hB3;
  localparam logic [BYTE_W-1:0] FB_ON       = 8'h11;
  localparam logic [BYTE_W-1:0] FB_OFF      = 8'hAA;

  typedef enum logic [KIND_W-1:0] {
    KIND_RX    = 2'd0,
    KIND_PRESS = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  // One feedback frame to send: new load level and the sticky flag at that moment.
  typedef struct packed {
    logic load;
    logic ovf;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic [ADDR_W-1:0] node_address;
    logic [DEB_W-1:0]  debounce_ms;
  } cfg_t;

  // Byte k of the feedback frame: fixed address, tag, state code, carriage return.
  function automatic logic [BYTE_W-1:0] feedback_byte(input logic [CNT_W-1:0] k,
                                                       input logic load);
    logic [BYTE_W-1:0] b;
    case (k)
      4'd0:    b = 8'h34;
      4'd1:    b = 8'h32;
      4'd2:    b = 8'h37;
      4'd3:    b = 8'h30;
      4'd4:    b = 8'h37;
      4'd5:    b = 8'h35;
      4'd6:    b = 8'h37;
      4'd7:    b = 8'h41;
      4'd8:    b = FB_TAG;
      4'd9:    b = load ? FB_ON : FB_OFF;
      default: b = CR_BYTE;
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/asc_in_if.sv @@
interface asc_in_if import asc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, kind, rx_byte, input ready);
  modport sink   (input valid, kind, rx_byte, output ready);
endinterface

@@ hw/rtl/asc_out_if.sv @@
interface asc_out_if import asc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] tx_byte;
  logic              frame_end;
  logic              load_on;
  logic              overflow_seen;

  modport source (output valid, tx_byte, frame_end, load_on, overflow_seen, input ready);
  modport sink   (input valid, tx_byte, frame_end, load_on, overflow_seen, output ready);
endinterface

@@ hw/rtl/asc_cfg_if.sv @@
interface asc_cfg_if import asc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/asc_front.sv @@
module asc_front import asc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_full,
  asc_in_if.sink      in_ch,
  output push_t       push
);

  logic [BYTE_W-1:0] store_r [KEPT_BYTES];
  logic [BYTE_W-1:0] store_nxt [KEPT_BYTES];
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              load_r, load_nxt;
  logic              ovf_r, ovf_nxt;
  logic [TIME_W-1:0] ms_r, ms_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              match;
  logic              accept;

  // Items are taken whenever the command queue has room.
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign elapsed     = ms_r - last_r;

  // Classify the transfer, update the frame and timer state, queue any load change.
  always_comb begin
    store_nxt      = store_r;
    idx_nxt        = idx_r;
    load_nxt       = load_r;
    ovf_nxt        = ovf_r;
    ms_nxt         = ms_r;
    last_nxt       = last_r;
    match          = 1'b1;
    push.valid     = 1'b0;
    push.cmd.load  = load_r;
    push.cmd.ovf   = ovf_r;
    if (accept) begin
      case (kind_t'(in_ch.kind))
        KIND_RX: begin
          if (idx_r < IDX_W'(BUFFER_SIZE - 1)) begin
            for (int i = 0; i < KEPT_BYTES; i++) begin
              if (idx_r == IDX_W'(i)) begin
                store_nxt[i] = in_ch.rx_byte;
              end
            end
            idx_nxt = idx_r + IDX_W'(1);
            if (in_ch.rx_byte == CR_BYTE) begin
              // Frame end: check the address and the switch command, then clear.
              idx_nxt = '0;
              for (int i = 0; i < ADDR_BYTES; i++) begin
                if (store_nxt[i] != cfg.node_address[ADDR_W-1-BYTE_W*i -: BYTE_W]) begin
                  match = 1'b0;
                end
              end
              if (match && store_nxt[CTRL_POS] == CTRL_SWITCH) begin
                if (store_nxt[DATA_POS] == DATA_ON && !load_r) begin
                  load_nxt   = 1'b1;
                  push.valid = 1'b1;
                end else if (store_nxt[DATA_POS] == DATA_OFF && load_r) begin
                  load_nxt   = 1'b0;
                  push.valid = 1'b1;
                end
              end
              for (int i = 0; i < KEPT_BYTES; i++) begin
                store_nxt[i] = '0;
              end
            end
          end else begin
            // Buffer full: drop the byte and restart the frame.
            ovf_nxt = 1'b1;
            idx_nxt = '0;
          end
        end
        KIND_PRESS: begin
          if (elapsed >= TIME_W'(cfg.debounce_ms)) begin
            last_nxt   = ms_r;
            load_nxt   = !load_r;
            push.valid = 1'b1;
          end
        end
        KIND_TICK: begin
          ms_nxt = ms_r + TIME_W'(1);
        end
        default: begin
        end
      endcase
      push.cmd.load = load_nxt;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEPT_BYTES; i++) begin
        store_r[i] <= '0;
      end
      idx_r  <= '0;
      load_r <= 1'b0;
      ovf_r  <= 1'b0;
      ms_r   <= '0;
      last_r <= '0;
    end else begin
      store_r <= store_nxt;
      idx_r   <= idx_nxt;
      load_r  <= load_nxt;
      ovf_r   <= ovf_nxt;
      ms_r    <= ms_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

@@ hw/rtl/asc_cmd_fifo.sv @@
module asc_cmd_fifo import asc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  input  logic    pop,
  output q_head_t head,
  output logic    full
);

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, wr_nxt;
  logic [Q_PTR_W-1:0] rd_r, rd_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.cmd   = mem_r[rd_r];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && head.valid;

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = wr_r + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = rd_r + Q_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push.cmd;
    end
  end

endmodule

@@ hw/rtl/asc_tx_seq.sv @@
module asc_tx_seq import asc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  q_head_t  head,
  output logic     pop,
  asc_out_if.source out_ch
);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic             last;
  logic             done;

  // Output fields are decoded combinationally from registers.
  assign out_ch.valid         = busy_r;
  assign out_ch.tx_byte       = feedback_byte(cnt_r, cmd_r.load);
  assign out_ch.frame_end     = last;
  assign out_ch.load_on       = cmd_r.load;
  assign out_ch.overflow_seen = cmd_r.ovf;

  assign last = (cnt_r == CNT_W'(FEEDBACK_LEN - 1));
  assign done = busy_r && out_ch.ready && last;
  assign pop  = head.valid && (!busy_r || done);

  // Step through the frame; take the next command on the cycle the last byte goes.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    cmd_nxt  = cmd_r;
    if (pop) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      cmd_nxt  = head.cmd;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r && out_ch.ready) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

@@ hw/rtl/addressed_switch_command_controller.sv @@
// A load change is queued, then loaded into the sequencer registers before its bytes go out.
// Throughput: one input item per cycle while the two-entry command queue has room.
// Each load change sends 11 feedback bytes, one per cycle while the sink is ready.
// Reset (rst_n low, synchronous) clears frame buffer, index, timer, load and flags;
// configuration returns to address zero and a debounce of 200 ms.
`include "addressed_switch_command_controller_assert.svh"

module addressed_switch_command_controller import asc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  asc_in_if.sink     in_ch,
  asc_out_if.source  out_ch,
  asc_cfg_if.sink    cfg_ch
);

  cfg_t    cfg_r;
  push_t   push;
  q_head_t head;
  logic    q_full;
  logic    pop;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_address <= '0;
      cfg_r.debounce_ms  <= DEBOUNCE_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_NODE_ADDRESS: cfg_r.node_address <= cfg_ch.data[ADDR_W-1:0];
        REG_DEBOUNCE_MS:  cfg_r.debounce_ms  <= cfg_ch.data[DEB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: frame assembly, debounce and load decisions.
  asc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_full (q_full),
    .in_ch  (in_ch),
    .push   (push)
  );

  // Queue of pending feedback frames.
  asc_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  // Back end: feedback frame sequencer.
  asc_tx_seq u_tx (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // A decision is never made while the queue cannot take it.
  `ASC_ASSERT_IMPLY(a_no_push_full, push.valid, !q_full, "command pushed into a full queue")
  // The closing byte of a feedback frame is always a carriage return.
  `ASC_ASSERT_IMPLY(a_end_is_cr, out_ch.valid && out_ch.frame_end, out_ch.tx_byte == CR_BYTE,
                    "feedback frame does not end with a carriage return")
  // A feedback frame is never broken off before its last byte.
  `ASC_ASSERT_NEXT(a_burst_whole, out_ch.valid && out_ch.ready && !out_ch.frame_end,
                   out_ch.valid, "feedback frame interrupted")

endmodule
